// ===== src/ashm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashm_pkg: shared types and constants of the allocation size monitor
// Beat structures, command codes, register indexes, reset values and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ashm_pkg;

    // Item command codes.
    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_REALLOC  = 3'd1;
    localparam logic [2:0] CMD_FREE     = 3'd2;
    localparam logic [2:0] CMD_TIME     = 3'd3;
    localparam logic [2:0] CMD_READ_BIN = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_THRESHOLD = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  RST_HEADER_BYTES     = 8'd32;
    localparam logic [31:0] RST_REPORT_INTERVAL  = 32'd10000;
    localparam logic [30:0] RST_REPORT_THRESHOLD = 31'd4;

    // Fixed arithmetic constants.
    localparam logic [31:0] GROSS_EXTRA = 32'd4;
    localparam int unsigned BIN_SHIFT   = 4;
    localparam logic [31:0] MB_ROUND    = 32'd1048575;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        old_present;
        logic [31:0] old_size;
        logic [31:0] new_size;
        logic [31:0] now_ticks;
        logic [10:0] bin_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] total_bytes;
        logic signed [11:0] total_mbytes;
        logic               report_due;
        logic signed [31:0] bin_delta;
        logic               bin_growing;
        logic               bin_skipped;
    } t_out_beat;

    // Controller to datapath.
    typedef struct packed {
        logic clr_step;  // clear one entry of both bin stores
        logic load;      // capture the input beat
        logic prep;      // form gross sizes, run the time check
        logic touch_rd;  // read a bin counter and update the total
        logic touch_wr;  // write the adjusted bin counter back
        logic sel_new;   // touch works on the new size (else the old one)
        logic bin_rd;    // read counter and snapshot of the requested bin
        logic snap;      // form the delta and store the snapshot
        logic finish;    // load the result register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       clr_last;
        logic [2:0] cmd;
        logic       old_present;
        logic       out_busy;
    } t_dp_stat;

endpackage

// ===== src/ashm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashm_ctrl: sequencing controller of the allocation size monitor
// Steps the datapath through the clearing pass and through each item.
// ----------------------------------------------------------------------------
module ashm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ashm_pkg::t_dp_stat i_stat,
    output ashm_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_RD_OLD = 4'd3;
    localparam logic [3:0] S_WR_OLD = 4'd4;
    localparam logic [3:0] S_RD_NEW = 4'd5;
    localparam logic [3:0] S_WR_NEW = 4'd6;
    localparam logic [3:0] S_RD_BIN = 4'd7;
    localparam logic [3:0] S_SNAP   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                unique case (i_stat.cmd)
                    ashm_pkg::CMD_ALLOC:    n_state = S_RD_NEW;
                    ashm_pkg::CMD_REALLOC:  n_state = i_stat.old_present ? S_RD_OLD : S_RD_NEW;
                    ashm_pkg::CMD_FREE:     n_state = i_stat.old_present ? S_RD_OLD : S_DONE;
                    ashm_pkg::CMD_READ_BIN: n_state = S_RD_BIN;
                    default:                n_state = S_DONE;
                endcase
            end
            S_RD_OLD: begin
                o_cmd.touch_rd = 1'b1;
                n_state        = S_WR_OLD;
            end
            S_WR_OLD: begin
                o_cmd.touch_wr = 1'b1;
                n_state = (i_stat.cmd == ashm_pkg::CMD_REALLOC) ? S_RD_NEW : S_DONE;
            end
            S_RD_NEW: begin
                o_cmd.touch_rd = 1'b1;
                o_cmd.sel_new  = 1'b1;
                n_state        = S_WR_NEW;
            end
            S_WR_NEW: begin
                o_cmd.touch_wr = 1'b1;
                o_cmd.sel_new  = 1'b1;
                n_state        = S_DONE;
            end
            S_RD_BIN: begin
                o_cmd.bin_rd = 1'b1;
                n_state      = S_SNAP;
            end
            S_SNAP: begin
                o_cmd.snap = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/ashm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashm_dp: datapath of the allocation size monitor
// Configuration registers, item register, running total, bin counter and
// snapshot memories, and the result register.
// ----------------------------------------------------------------------------
module ashm_dp #(
    parameter int unsigned NUM_BINS = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [ashm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ashm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  ashm_pkg::t_in_beat                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ashm_pkg::t_out_beat               o_out_data,
    input  ashm_pkg::t_dp_cmd                 i_cmd,
    output ashm_pkg::t_dp_stat                o_stat
);

    localparam int unsigned IDX_W = $clog2(NUM_BINS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_BINS - 1);
    localparam logic [31:0] NUM_BINS_W = 32'(NUM_BINS);

    logic [31:0] r_bin_counts    [NUM_BINS];
    logic [31:0] r_bin_snapshots [NUM_BINS];

    logic [7:0]  r_cfg_header;
    logic [31:0] r_cfg_interval;
    logic [30:0] r_cfg_threshold;

    ashm_pkg::t_in_beat  r_item;
    ashm_pkg::t_out_beat r_out;
    logic                r_out_valid;

    logic [IDX_W-1:0] r_clr_addr;
    logic [31:0]      r_total;
    logic [31:0]      r_last_report;
    logic [31:0]      r_g_old;
    logic [31:0]      r_g_new;
    logic             r_due;
    logic             r_skip;
    logic             r_hit;
    logic [IDX_W-1:0] r_addr;
    logic [31:0]      r_cnt_rd;
    logic [31:0]      r_snap_rd;
    logic [31:0]      r_delta;

    logic             w_realloc;
    logic [31:0]      w_g_old;
    logic [31:0]      w_g_new;
    logic [31:0]      w_g_sel;
    logic [31:0]      w_g_bin;
    logic [31:0]      w_req_bin;
    logic             w_g_hit;
    logic             w_req_hit;
    logic [IDX_W-1:0] w_rd_addr;
    logic [31:0]      w_due_at;
    logic             w_cnt_we;
    logic [IDX_W-1:0] w_cnt_waddr;
    logic [31:0]      w_cnt_wdata;
    logic             w_snap_we;
    logic [IDX_W-1:0] w_snap_waddr;
    logic [31:0]      w_snap_wdata;
    logic [31:0]      w_mb_adj;
    logic             w_growing;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_header    <= ashm_pkg::RST_HEADER_BYTES;
            r_cfg_interval  <= ashm_pkg::RST_REPORT_INTERVAL;
            r_cfg_threshold <= ashm_pkg::RST_REPORT_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ashm_pkg::CFG_HEADER_BYTES:     r_cfg_header    <= i_cfg_data[7:0];
                ashm_pkg::CFG_REPORT_INTERVAL:  r_cfg_interval  <= i_cfg_data;
                ashm_pkg::CFG_REPORT_THRESHOLD: r_cfg_threshold <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Gross sizes; a realloc size of zero maps to gross zero, i.e. bin zero.
    assign w_realloc = (r_item.cmd == ashm_pkg::CMD_REALLOC);
    assign w_g_old = (w_realloc && (r_item.old_size == '0)) ? '0 :
                     32'(r_cfg_header) + r_item.old_size + ashm_pkg::GROSS_EXTRA;
    assign w_g_new = (w_realloc && (r_item.new_size == '0)) ? '0 :
                     32'(r_cfg_header) + r_item.new_size + ashm_pkg::GROSS_EXTRA;
    assign w_due_at = r_last_report + r_cfg_interval;

    assign w_g_sel   = i_cmd.sel_new ? r_g_new : r_g_old;
    assign w_g_bin   = w_g_sel >> ashm_pkg::BIN_SHIFT;
    assign w_g_hit   = (w_g_bin < NUM_BINS_W);
    assign w_req_bin = 32'(r_item.bin_index);
    assign w_req_hit = (w_req_bin < NUM_BINS_W);
    assign w_rd_addr = i_cmd.bin_rd ? w_req_bin[IDX_W-1:0] : w_g_bin[IDX_W-1:0];

    // Item, total and per-item working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_total       <= '0;
            r_last_report <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.prep && (r_item.cmd == ashm_pkg::CMD_TIME) &&
                (r_item.now_ticks > w_due_at)) begin
                r_last_report <= r_item.now_ticks;
            end
            if (i_cmd.touch_rd) begin
                r_total <= i_cmd.sel_new ? r_total + w_g_sel : r_total - w_g_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_data;
            r_due   <= 1'b0;
            r_skip  <= 1'b0;
            r_delta <= '0;
        end
        if (i_cmd.prep) begin
            r_g_old <= w_g_old;
            r_g_new <= w_g_new;
            r_due   <= (r_item.cmd == ashm_pkg::CMD_TIME) && (r_item.now_ticks > w_due_at);
        end
        if (i_cmd.touch_rd) begin
            r_hit  <= w_g_hit;
            r_addr <= w_rd_addr;
            if (!w_g_hit) begin
                r_skip <= 1'b1;
            end
        end
        if (i_cmd.bin_rd) begin
            r_hit  <= w_req_hit;
            r_addr <= w_rd_addr;
        end
        if (i_cmd.snap && r_hit) begin
            r_delta <= r_cnt_rd - r_snap_rd;
        end
    end

    // Bin counter memory: one write and one read port.
    assign w_cnt_we    = i_cmd.clr_step || (i_cmd.touch_wr && r_hit);
    assign w_cnt_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign w_cnt_wdata = i_cmd.clr_step ? '0 :
                         (i_cmd.sel_new ? r_cnt_rd + 32'd1 : r_cnt_rd - 32'd1);

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_bin_counts[w_cnt_waddr] <= w_cnt_wdata;
        end
        if (i_cmd.touch_rd || i_cmd.bin_rd) begin
            r_cnt_rd <= r_bin_counts[w_rd_addr];
        end
    end

    // Snapshot memory.
    assign w_snap_we    = i_cmd.clr_step || (i_cmd.snap && r_hit);
    assign w_snap_waddr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign w_snap_wdata = i_cmd.clr_step ? '0 : r_cnt_rd;

    always_ff @(posedge i_clk) begin
        if (w_snap_we) begin
            r_bin_snapshots[w_snap_waddr] <= w_snap_wdata;
        end
        if (i_cmd.bin_rd) begin
            r_snap_rd <= r_bin_snapshots[w_rd_addr];
        end
    end

    // Result register; the megabyte figure rounds toward zero.
    assign w_mb_adj  = r_total + (r_total[31] ? ashm_pkg::MB_ROUND : '0);
    assign w_growing = ($signed(r_delta) > $signed({1'b0, r_cfg_threshold}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.total_bytes  <= r_total;
            r_out.total_mbytes <= w_mb_adj[31:20];
            r_out.report_due   <= r_due;
            r_out.bin_delta    <= r_delta;
            r_out.bin_growing  <= w_growing;
            r_out.bin_skipped  <= r_skip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.clr_last    = (r_clr_addr == LAST_ADDR);
    assign o_stat.cmd         = r_item.cmd;
    assign o_stat.old_present = r_item.old_present;
    assign o_stat.out_busy    = r_out_valid && !i_out_ready;

endmodule

// ===== src/alloc_size_histogram_monitor.sv =====
`timescale 1ns / 1ps
// Per item: capture, gross size formation, then one bin update for alloc, free or a
// realloc without an old block, two for a realloc with an old block, none for a time
// check, a free of no block or an unused command, or a counter and snapshot read for a
// bin read. A final step, held while the last result is unread, loads the result
// register; no item is taken before it, as each bin update is a serial read then write.
// Reset: synchronous, active low; no input beat is taken while both bin stores are zeroed.
// ----------------------------------------------------------------------------
// alloc_size_histogram_monitor: heap size histogram monitor
// Keeps a running gross byte total and a histogram of block sizes from
// allocation events, reports elapsed intervals and per-bin growth.
// ----------------------------------------------------------------------------
module alloc_size_histogram_monitor #(
    parameter int unsigned NUM_BINS = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ashm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ashm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Item channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ashm_pkg::t_in_beat              i_in_data,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ashm_pkg::t_out_beat             o_out_data
);

    // The controller owns sequencing only; all storage and arithmetic sit in
    // the datapath. They talk through one command and one status bundle.
    ashm_pkg::t_dp_cmd  w_cmd;
    ashm_pkg::t_dp_stat w_stat;

    // Configuration writes are always taken. The user must issue them only while the block
    // is idle, so no item sees a register change mid-flight; no logic enforces it.
    assign o_cfg_ready = 1'b1;

    // The controller walks each item through its steps: capture, gross size
    // formation, zero, one or two bin read-modify-write passes (the old block is
    // released before the new one is counted), or a counter and snapshot
    // read for a bin read, then a final step that loads the result register.
    // That last step waits only while the previous result is still unread,
    // so a new beat is accepted while a finished result waits downstream.
    ashm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the two bin memories, each read and written at one
    // address per cycle. Since each write lands before the next read of the
    // same item samples the memory, no forwarding is needed between the old
    // and new halves of a realloc even when both land in the same bin.
    ashm_dp #(
        .NUM_BINS (NUM_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ===== src/ashm_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ashm_chk: port-level checker of the allocation size monitor
// Watches the top-level channels for ordering, clearing and flag consistency.
// ----------------------------------------------------------------------------
module ashm_chk #(
    parameter int unsigned NUM_BINS = 2048
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ashm_pkg::t_out_beat o_out_data
);

    localparam int unsigned SW = $clog2(NUM_BINS + 1);
    localparam logic [SW-1:0] CLEAR_LEN = SW'(NUM_BINS);

    logic [SW-1:0] r_since;
    logic [1:0]    r_pend;
    logic          w_in_acc;
    logic          w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_pend  <= '0;
        end else begin
            if (r_since != CLEAR_LEN) begin
                r_since <= r_since + 1'b1;
            end
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    // No beat is taken while the bin stores are being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_since != CLEAR_LEN) |-> !o_in_ready)
        else $error("item ready during clearing pass");

    // At most one item at work and one result waiting.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend <= 2'd2) && (!o_out_valid || (r_pend != 2'd0)))
        else $error("results out of step with accepted items");

    // A growing flag needs a positive delta.
    a_growing_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bin_growing) |->
        (!o_out_data.bin_delta[31] && (o_out_data.bin_delta != '0)))
        else $error("bin flagged growing without positive delta");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind alloc_size_histogram_monitor ashm_chk #(
    .NUM_BINS (NUM_BINS)
) u_ashm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
